// ===== rtl/core/lbwp_pkg.sv =====
// ----------------------------------------------------------------------------
// lbwp_pkg: shared types and constants for the landmark pose block
// Payload structs, pipeline control and rotation records, register indexes
// and the arctangent table of the rotation stages.
// ----------------------------------------------------------------------------
`default_nettype none

package lbwp_pkg;

  // Fixed field widths
  localparam int COL_W   = 16;
  localparam int ANG_W   = 16;
  localparam int RANGE_W = 31;
  localparam int OUT_C_W = 32;
  localparam int CFG_W   = 32;

  // Rotation datapath: scaled range is 47 bits, growth needs two more plus sign
  localparam int XY_W    = 50;
  localparam int Z_W     = 34;
  localparam int RND_W   = XY_W - 16;
  localparam int MAX_STG = 24;

  // round(2^32 * 0.60725293501), inverse rotation gain
  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  // Quarter turn in 32-bit turn units
  localparam logic signed [Z_W-1:0] Z_QUARTER = 34'sd1073741824;

  // Register indexes
  typedef enum logic [2:0] {
    REG_LANDMARK_X      = 3'd0,
    REG_LANDMARK_Z      = 3'd1,
    REG_ANGLE_AT_MAX    = 3'd2,
    REG_ANGLE_AT_MIN    = 3'd3,
    REG_LANDMARK_COLUMN = 3'd4
  } lbwp_reg_e;

  typedef struct packed {
    logic        [COL_W-1:0]   split_column;
    logic signed [ANG_W-1:0]   view_angle;
    logic        [RANGE_W-1:0] range;
    logic signed [ANG_W-1:0]   relative_azimuth;
  } lbwp_in_t;

  typedef struct packed {
    logic signed [OUT_C_W-1:0] world_x;
    logic signed [OUT_C_W-1:0] world_z;
    logic        [ANG_W-1:0]   world_azimuth;
    logic                      on_max_side;
  } lbwp_out_t;

  // Control travelling with each item down the pipe
  typedef struct packed {
    logic             valid;
    logic             on_max_side;
    logic [ANG_W-1:0] world_azimuth;
  } lbwp_ctl_t;

  // Rotation vector and residual angle
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } lbwp_rot_t;

  // atan(2^-i) in 32-bit turn units, rounded to nearest
  function automatic logic [29:0] lbwp_atan(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458906;
      5'd3:    v = 30'd85004755;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lbwp_front.sv =====
// ----------------------------------------------------------------------------
// lbwp_front: side selection, angle arithmetic and range scaling
// Two register stages: angle sums and gain product, then the folded start
// vector of the rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module lbwp_front import lbwp_pkg::*; #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  lbwp_in_t              in_item,
  input  logic [ANGLE_BITS-1:0] angle_at_max,
  input  logic [ANGLE_BITS-1:0] angle_at_min,
  input  logic [COL_W-1:0]      landmark_column,
  output lbwp_ctl_t             ctl_o,
  output lbwp_rot_t             rot_o
);

  localparam logic [ANGLE_BITS-1:0] QTR_TURN = {2'b01, {(ANGLE_BITS-2){1'b0}}};

  logic                  on_max;
  logic [ANGLE_BITS-1:0] view_a;
  logic [ANGLE_BITS-1:0] rel_a;
  logic [ANGLE_BITS-1:0] adj;
  logic [ANGLE_BITS-1:0] azim;
  logic [31:0]           a32;
  logic                  fold;
  logic [62:0]           prod;

  lbwp_ctl_t   ctl1_r, ctl1_nxt;
  logic [31:0] zf1_r, zf1_nxt;
  logic        neg1_r, neg1_nxt;
  logic [62:0] prod1_r;

  lbwp_ctl_t              ctl2_r;
  lbwp_rot_t              rot2_r, rot2_nxt;
  logic signed [XY_W-1:0] x_mag;

  // Side choice and angle sums, all modulo one turn
  always_comb begin
    on_max = landmark_column > in_item.split_column;
    view_a = ANGLE_BITS'($unsigned(in_item.view_angle));
    rel_a  = ANGLE_BITS'($unsigned(in_item.relative_azimuth));
    adj    = on_max ? (angle_at_max - view_a) : (angle_at_min + view_a);
    azim   = adj - rel_a - QTR_TURN;
    a32    = 32'(adj) << (32 - ANGLE_BITS);
    // beyond a quarter turn either way: rotate by a half turn, negate vector
    fold   = ($signed(a32) > 32'sd1073741824) || ($signed(a32) < -32'sd1073741824);
    prod   = 63'(in_item.range) * 63'(INV_GAIN);

    ctl1_nxt.valid         = start;
    ctl1_nxt.on_max_side   = on_max;
    ctl1_nxt.world_azimuth = ANG_W'(azim);
    zf1_nxt                = fold ? (a32 ^ 32'h8000_0000) : a32;
    neg1_nxt               = fold;
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.valid <= 1'b0;
    end else begin
      ctl1_r <= ctl1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    zf1_r   <= zf1_nxt;
    neg1_r  <= neg1_nxt;
    prod1_r <= prod;
  end

  // Start vector: scaled range on x, signed by the fold
  always_comb begin
    x_mag      = $signed(XY_W'(prod1_r[62:16]));
    rot2_nxt.x = neg1_r ? -x_mag : x_mag;
    rot2_nxt.y = '0;
    rot2_nxt.z = Z_W'($signed(zf1_r));
  end

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r.valid <= 1'b0;
    end else begin
      ctl2_r <= ctl1_r;
    end
  end

  always_ff @(posedge clk) begin
    rot2_r <= rot2_nxt;
  end

  assign ctl_o = ctl2_r;
  assign rot_o = rot2_r;

`ifndef SYNTH
  a_fold_in_quarter: assert property (@(posedge clk) disable iff (!rst_n)
    ctl2_r.valid |-> (rot2_r.z <= Z_QUARTER) && (rot2_r.z >= -Z_QUARTER))
    else $error("folded angle outside a quarter turn");

  a_stage_follow: assert property (@(posedge clk) disable iff (!rst_n)
    ctl1_r.valid |=> ctl2_r.valid)
    else $error("item lost between front stages");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lbwp_rot_stage.sv =====
// ----------------------------------------------------------------------------
// lbwp_rot_stage: one registered rotation stage
// Rotates the vector by plus or minus atan(2^-STAGE) towards zero residual.
// ----------------------------------------------------------------------------
`default_nettype none

module lbwp_rot_stage import lbwp_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  lbwp_ctl_t ctl_i,
  input  lbwp_rot_t rot_i,
  output lbwp_ctl_t ctl_o,
  output lbwp_rot_t rot_o
);

  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  step_z;
  lbwp_ctl_t              ctl_r;
  lbwp_rot_t              rot_r, rot_nxt;

  // Floor shifts and micro-rotation; zero residual rotates positive
  always_comb begin
    dx     = $signed(rot_i.y) >>> STAGE;
    dy     = $signed(rot_i.x) >>> STAGE;
    step_z = $signed(Z_W'(lbwp_atan(5'(STAGE))));
    if (rot_i.z >= 0) begin
      rot_nxt.x = rot_i.x - dx;
      rot_nxt.y = rot_i.y + dy;
      rot_nxt.z = rot_i.z - step_z;
    end else begin
      rot_nxt.x = rot_i.x + dx;
      rot_nxt.y = rot_i.y - dy;
      rot_nxt.z = rot_i.z + step_z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rot_r <= rot_nxt;
  end

  assign ctl_o = ctl_r;
  assign rot_o = rot_r;

endmodule

`default_nettype wire

// ===== rtl/core/lbwp_back.sv =====
// ----------------------------------------------------------------------------
// lbwp_back: rounding, landmark offset and saturation
// Rounds the rotated vector to Q16.16, adds it to the landmark position and
// clamps to the coordinate width.
// ----------------------------------------------------------------------------
`default_nettype none

module lbwp_back import lbwp_pkg::*; #(
  parameter int COORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lbwp_ctl_t             ctl_i,
  input  lbwp_rot_t             rot_i,
  input  logic [COORD_BITS-1:0] landmark_x,
  input  logic [COORD_BITS-1:0] landmark_z,
  output logic                  out_strobe,
  output lbwp_out_t             out_result
);

  localparam int SUM_W = ((COORD_BITS > RND_W) ? COORD_BITS : RND_W) + 1;
  localparam logic signed [XY_W-1:0] HALF_LSB = XY_W'(32768);

  logic signed [XY_W-1:0]  xs, ys;
  lbwp_ctl_t               ctl_a_r;
  logic signed [RND_W-1:0] xr_r, yr_r;

  logic signed [SUM_W-1:0] sum_x, sum_z;
  logic                    strobe_r;
  lbwp_out_t               out_r, out_nxt;

  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_BITS:0] upper;
    logic [COORD_BITS-1:0]     res;
    upper = v[SUM_W-1:COORD_BITS-1];
    if ((&upper) || !(|upper)) begin
      res = v[COORD_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      res = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return res;
  endfunction

  // Round half up to Q16.16
  assign xs = rot_i.x + HALF_LSB;
  assign ys = rot_i.y + HALF_LSB;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r.valid <= 1'b0;
    end else begin
      ctl_a_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    xr_r <= $signed(xs[XY_W-1:16]);
    yr_r <= $signed(ys[XY_W-1:16]);
  end

  // Landmark plus cos term, landmark minus sin term, clamped
  always_comb begin
    sum_x = SUM_W'($signed(landmark_x)) + SUM_W'(xr_r);
    sum_z = SUM_W'($signed(landmark_z)) - SUM_W'(yr_r);
    out_nxt.world_x       = OUT_C_W'(sat_coord(sum_x));
    out_nxt.world_z       = OUT_C_W'(sat_coord(sum_z));
    out_nxt.world_azimuth = ctl_a_r.world_azimuth;
    out_nxt.on_max_side   = ctl_a_r.on_max_side;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl_a_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_result = out_r;

`ifndef SYNTH
  a_round_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_a_r.valid |=> strobe_r)
    else $error("rounded item did not reach the output");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/landmark_bearing_to_world_pose.sv =====
// ----------------------------------------------------------------------------
// landmark_bearing_to_world_pose: robot ground pose from one landmark sighting
// Picks the landmark angle by image side, rotates the range through a
// pipelined CORDIC and adds the landmark position; also gives world azimuth.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  input    start / busy           in_item    (lbwp_in_t)
//  result   out_strobe             out_result (lbwp_out_t)
//  config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle. Pipeline order: two front stages (side select and gain
// multiply, then start vector), the rotation stages, then rounding and the
// saturating landmark add.
// Synchronous reset clears the valid bits and the configuration registers.
// The result cannot be held off; busy stays low and nothing stalls.
// Config transfers are always taken (cfg_ready high) and apply next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module landmark_bearing_to_world_pose import lbwp_pkg::*; #(
  parameter int ANGLE_BITS    = 16,
  parameter int COORD_BITS    = 32,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  lbwp_in_t    in_item,
  output logic        out_strobe,
  output lbwp_out_t   out_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int NSTG = (CORDIC_STAGES > MAX_STG) ? MAX_STG : CORDIC_STAGES;

  logic [COORD_BITS-1:0] lx_r, lz_r;
  logic [ANGLE_BITS-1:0] amax_r, amin_r;
  logic [COL_W-1:0]      col_r;
  logic                  cfg_wr;

  lbwp_ctl_t ctl_s [NSTG+1];
  lbwp_rot_t rot_s [NSTG+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r   <= '0;
      lz_r   <= '0;
      amax_r <= '0;
      amin_r <= '0;
      col_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_LANDMARK_X:      lx_r   <= COORD_BITS'(cfg_data);
        REG_LANDMARK_Z:      lz_r   <= COORD_BITS'(cfg_data);
        REG_ANGLE_AT_MAX:    amax_r <= ANGLE_BITS'(cfg_data);
        REG_ANGLE_AT_MIN:    amin_r <= ANGLE_BITS'(cfg_data);
        REG_LANDMARK_COLUMN: col_r  <= COL_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // Front end: side, angles, scaled and folded start vector
  lbwp_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start && !busy),
    .in_item         (in_item),
    .angle_at_max    (amax_r),
    .angle_at_min    (amin_r),
    .landmark_column (col_r),
    .ctl_o           (ctl_s[0]),
    .rot_o           (rot_s[0])
  );

  // Rotation pipeline
  for (genvar i = 0; i < NSTG; i++) begin : g_rot
    lbwp_rot_stage #(
      .STAGE(i)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_s[i]),
      .rot_i (rot_s[i]),
      .ctl_o (ctl_s[i+1]),
      .rot_o (rot_s[i+1])
    );
  end

  // Rounding and landmark offset
  lbwp_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl_s[NSTG]),
    .rot_i      (rot_s[NSTG]),
    .landmark_x (lx_r),
    .landmark_z (lz_r),
    .out_strobe (out_strobe),
    .out_result (out_result)
  );

`ifndef SYNTH
  a_cfg_lx_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (cfg_index == REG_LANDMARK_X) |=> (lx_r == $past(COORD_BITS'(cfg_data))))
    else $error("landmark X transfer not stored");
`endif

endmodule

`default_nettype wire
